// ===== rtl/dmva_pkg.sv =====
// dmva_pkg: shared widths, mode codes and lane control type for the
// dual matrix-vector accumulator; no dependencies
`default_nettype none

package dmva_pkg;

  localparam int unsigned VECTOR_LENGTH_DEF = 4096;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned FIX_W = 32;
  localparam int unsigned SUM_W = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ACC  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic fwd_hit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dmva_if.sv =====
// dmva_if: command and result channel interfaces with valid/ready handshake
// depends on dmva_pkg
`default_nettype none

interface dmva_cmd_if import dmva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [FIX_W-1:0] a_value;
  logic signed [FIX_W-1:0] x_at_row;
  logic signed [FIX_W-1:0] x_at_col;
  logic signed [SUM_W-1:0] load_y;
  logic signed [SUM_W-1:0] load_z;

  modport source (output valid, mode, row, col, a_value, x_at_row, x_at_col,
                  load_y, load_z, input ready);
  modport sink (input valid, mode, row, col, a_value, x_at_row, x_at_col,
                load_y, load_z, output ready);
endinterface

interface dmva_res_if import dmva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        entry_index;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] z_sum;
  logic                    saturated;

  modport source (output valid, entry_index, y_sum, z_sum, saturated, input ready);
  modport sink (input valid, entry_index, y_sum, z_sum, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_matrix_vector_accumulate.sv =====
// dual_matrix_vector_accumulate: y += A^T x and z += A x in two entry memories
// depends on dmva_pkg, dmva_if, dmva_ram, dmva_lane
//
//   port    dir   role     payload
//   cmd     in    sink     mode row col a_value x_at_row x_at_col load_y load_z
//   result  out   source   entry_index y_sum z_sum saturated
//
// one transaction per cycle; both memories are read at acceptance and the
// entry is written back in the following cycle, with a forwarding register per memory
// covering a hit on the entry written in that same cycle
// a read transaction delivers its result through the stage register and then the result register
// cmd stalls only while a read waits behind an unaccepted result
// synchronous reset clears control and the sticky flag; memory is not cleared
`default_nettype none

module dual_matrix_vector_accumulate
  import dmva_pkg::*;
#(
  parameter int unsigned VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  dmva_cmd_if.sink   cmd,
  dmva_res_if.source result
);

  localparam int unsigned ADDR_W = $clog2(VECTOR_LENGTH);

  logic                    cmd_accept;
  logic                    row_ok;
  logic                    col_ok;
  logic                    dec_y_en;
  logic                    dec_z_en;
  logic [ADDR_W-1:0]       y_raddr;
  logic [ADDR_W-1:0]       z_raddr;
  logic signed [SUM_W-1:0] prod_y;
  logic signed [SUM_W-1:0] prod_z;

  logic                    s1_valid;
  logic [1:0]              s1_mode;
  logic [IDX_W-1:0]        s1_row;
  logic [ADDR_W-1:0]       s1_y_addr;
  logic [ADDR_W-1:0]       s1_z_addr;
  logic                    s1_y_en;
  logic                    s1_z_en;
  logic signed [SUM_W-1:0] s1_y_val;
  logic signed [SUM_W-1:0] s1_z_val;
  logic                    s1_adv;
  logic                    s1_read;
  logic                    s1_write;

  logic                    fwd_y_hit;
  logic                    fwd_z_hit;
  logic signed [SUM_W-1:0] fwd_y;
  logic signed [SUM_W-1:0] fwd_z;

  logic [SUM_W-1:0]        y_rdata;
  logic [SUM_W-1:0]        z_rdata;
  logic signed [SUM_W-1:0] y_operand;
  logic signed [SUM_W-1:0] z_operand;
  logic signed [SUM_W-1:0] y_wdata;
  logic signed [SUM_W-1:0] z_wdata;
  logic                    y_ovf;
  logic                    z_ovf;
  logic                    y_we;
  logic                    z_we;
  lane_ctrl_t              y_ctrl;
  lane_ctrl_t              z_ctrl;

  logic                    overflow_seen;
  logic                    res_valid;
  logic                    res_load;

  // command decode
  assign row_ok  = 32'(cmd.row) < VECTOR_LENGTH;
  assign col_ok  = 32'(cmd.col) < VECTOR_LENGTH;
  assign z_raddr = ADDR_W'(cmd.row);
  assign prod_y  = cmd.a_value * cmd.x_at_row;
  assign prod_z  = cmd.a_value * cmd.x_at_col;

  always_comb begin
    unique case (cmd.mode)
      MODE_LOAD: begin
        dec_y_en = row_ok;
        dec_z_en = row_ok;
        y_raddr  = ADDR_W'(cmd.row);
      end
      MODE_ACC: begin
        dec_y_en = col_ok;
        dec_z_en = row_ok;
        y_raddr  = ADDR_W'(cmd.col);
      end
      MODE_READ: begin
        dec_y_en = row_ok;
        dec_z_en = row_ok;
        y_raddr  = ADDR_W'(cmd.row);
      end
      default: begin
        dec_y_en = 1'b0;
        dec_z_en = 1'b0;
        y_raddr  = ADDR_W'(cmd.row);
      end
    endcase
  end

  // stage control
  assign s1_read    = s1_mode == MODE_READ;
  assign s1_write   = (s1_mode == MODE_LOAD) || (s1_mode == MODE_ACC);
  assign s1_adv     = !(s1_read && res_valid && !result.ready);
  assign cmd.ready  = !s1_valid || s1_adv;
  assign cmd_accept = cmd.valid && cmd.ready;
  assign res_load   = s1_valid && s1_read && s1_adv;

  assign y_we = s1_valid && s1_write && s1_y_en;
  assign z_we = s1_valid && s1_write && s1_z_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_mode   <= MODE_LOAD;
      s1_y_en   <= 1'b0;
      s1_z_en   <= 1'b0;
      fwd_y_hit <= 1'b0;
      fwd_z_hit <= 1'b0;
    end else if (cmd_accept) begin
      s1_valid  <= 1'b1;
      s1_mode   <= cmd.mode;
      s1_y_en   <= dec_y_en;
      s1_z_en   <= dec_z_en;
      fwd_y_hit <= y_we && (s1_y_addr == y_raddr);
      fwd_z_hit <= z_we && (s1_z_addr == z_raddr);
    end else if (s1_adv) begin
      s1_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_row    <= cmd.row;
      s1_y_addr <= y_raddr;
      s1_z_addr <= z_raddr;
      s1_y_val  <= (cmd.mode == MODE_LOAD) ? cmd.load_y : prod_y;
      s1_z_val  <= (cmd.mode == MODE_LOAD) ? cmd.load_z : prod_z;
      fwd_y     <= y_wdata;
      fwd_z     <= z_wdata;
    end
  end

  // accumulator memories
  dmva_ram #(.WIDTH(SUM_W), .DEPTH(VECTOR_LENGTH)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (s1_y_addr),
    .wdata (y_wdata),
    .re    (cmd_accept),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  dmva_ram #(.WIDTH(SUM_W), .DEPTH(VECTOR_LENGTH)) u_z_ram (
    .clk   (clk),
    .we    (z_we),
    .waddr (s1_z_addr),
    .wdata (z_wdata),
    .re    (cmd_accept),
    .raddr (z_raddr),
    .rdata (z_rdata)
  );

  assign y_ctrl = '{load: s1_mode == MODE_LOAD, acc: s1_mode == MODE_ACC,
                    fwd_hit: fwd_y_hit};
  assign z_ctrl = '{load: s1_mode == MODE_LOAD, acc: s1_mode == MODE_ACC,
                    fwd_hit: fwd_z_hit};

  dmva_lane u_y_lane (
    .ctrl     (y_ctrl),
    .rdata    (y_rdata),
    .fwd_data (fwd_y),
    .value    (s1_y_val),
    .operand  (y_operand),
    .wdata    (y_wdata),
    .ovf      (y_ovf)
  );

  dmva_lane u_z_lane (
    .ctrl     (z_ctrl),
    .rdata    (z_rdata),
    .fwd_data (fwd_z),
    .value    (s1_z_val),
    .operand  (z_operand),
    .wdata    (z_wdata),
    .ovf      (z_ovf)
  );

  // sticky saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (s1_valid && ((y_we && y_ovf) || (z_we && z_ovf))) begin
      overflow_seen <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.entry_index <= s1_row;
      result.y_sum       <= s1_y_en ? y_operand : '0;
      result.z_sum       <= s1_z_en ? z_operand : '0;
      result.saturated   <= overflow_seen;
    end
  end

  assign result.valid = res_valid;

  // checks
  a_stall_only_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> s1_read)
    else $error("stage stalled on a non-read transaction");

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    $past(cmd_accept) && fwd_y_hit |-> $past(y_we))
    else $error("y forward hit without a write");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("saturation flag cleared");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid && s1_read))
    else $error("result without a read transaction");

endmodule

`default_nettype wire

// ===== rtl/dmva_ram.sv =====
// dmva_ram: generic single-write, single-read synchronous ram, registered read
// returns old data on a same-address read and write; no dependencies
`default_nettype none

module dmva_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmva_lane.sv =====
// dmva_lane: read-modify-write datapath of one accumulator memory
// forward select, saturating add, load replace; depends on dmva_pkg
`default_nettype none

module dmva_lane
  import dmva_pkg::*;
(
  input  wire lane_ctrl_t              ctrl,
  input  wire logic signed [SUM_W-1:0] rdata,
  input  wire logic signed [SUM_W-1:0] fwd_data,
  input  wire logic signed [SUM_W-1:0] value,
  output      logic signed [SUM_W-1:0] operand,
  output      logic signed [SUM_W-1:0] wdata,
  output      logic                    ovf
);

  logic signed [SUM_W-1:0] sum;
  logic                    raw_ovf;

  assign operand = ctrl.fwd_hit ? fwd_data : rdata;
  assign sum     = operand + value;
  assign raw_ovf = (operand[SUM_W-1] == value[SUM_W-1]) &&
                   (sum[SUM_W-1] != operand[SUM_W-1]);
  assign ovf     = ctrl.acc && raw_ovf;

  always_comb begin
    if (ctrl.load) begin
      wdata = value;
    end else if (raw_ovf) begin
      wdata = operand[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      wdata = sum;
    end
  end

endmodule

`default_nettype wire
